// File: rtl/assert_macros.svh
// assertion helpers used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, ignored while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ocws_pkg.sv
package ocws_pkg;

   // fixed shape of the solver
   localparam int WHEEL_COUNT = 4;
   localparam int VEL_W = 16;
   localparam int SINE_W = 16;
   localparam int TRIG_W = 17;
   localparam int PROD_W = 33;
   localparam int RIM_W = 34;
   localparam int TENTHS_W = 9;
   localparam int RATE_W = 16;
   localparam int WHEEL_RATE_W = 25;

   // phase of wheel 0 at zero heading, 3/8 of a turn
   localparam logic [15:0] PHASE_OFFSET = 16'd24576;

   // saturation of the rounded rim speed, in tenths of m/s
   localparam logic [9:0] TENTHS_LIMIT = 10'd200;

   // rounding constant for the Q27 to tenths conversion
   localparam logic [36:0] ROUND_HALF = 37'd67108864;

   // sine table generation: pi/2 in Q30 and the Taylor divisors 2n(2n+1)
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int TAYLOR_TERMS = 12;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
   localparam logic [15:0] SINE_MAX = 16'd32768;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_RATE = 1'b0;
   localparam logic [RATE_W-1:0] RATE_RESET = 16'd853;

   typedef logic signed [VEL_W-1:0] vel_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [RIM_W-1:0] rim_type;
   typedef logic signed [TENTHS_W-1:0] tenths_type;
   typedef logic signed [WHEEL_RATE_W-1:0] wheel_rate_type;

endpackage

// File: rtl/ocws_sine_rom.sv
module ocws_sine_rom
   import ocws_pkg::*;
#(
   parameter int SINE_ROM_DEPTH = 256,
   parameter int IDX_W = 9
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  addr_a,
   input  logic [IDX_W-1:0]  addr_b,
   output logic [SINE_W-1:0] data_a,
   output logic [SINE_W-1:0] data_b
);

   typedef logic [SINE_W-1:0] rom_type [0:SINE_ROM_DEPTH];

   // quarter-wave table in Q15, built at elaboration from a truncated Taylor series
   function automatic rom_type build_rom();
      rom_type               rom;
      longint unsigned       x;
      longint unsigned       x2;
      longint unsigned       term;
      longint                sum;
      longint unsigned       e;
      for (int k = 0; k <= SINE_ROM_DEPTH; k++) begin
         x = (longint'(k) * HALF_PI_Q30) / SINE_ROM_DEPTH;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int n = 0; n < TAYLOR_TERMS; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 0) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         e = (longint'(sum) + 64'd16384) >> 15;
         rom[k] = (e > 64'(SINE_MAX)) ? SINE_MAX : e[SINE_W-1:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_TABLE = build_rom();

   logic [SINE_W-1:0] data_a_ff;
   logic [SINE_W-1:0] data_b_ff;

   // two registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= SINE_TABLE[addr_a];
         data_b_ff <= SINE_TABLE[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

// File: rtl/omni_chassis_wheel_speed_solver_core.sv
// Four-wheel omni chassis speed solver. Each request carries a chassis
// velocity (vel_x, vel_y, Q12 m/s), a rotation term vel_turn subtracted from
// every wheel and a heading (65536 = one turn). The block answers every
// request with four signed Q8 rad/s wheel setpoints and a clipped flag that is
// set when any wheel's rim speed, rounded half away from zero to tenths of
// m/s, had to be saturated to +-200 tenths. The setpoint is the rounded tenths
// value times rate_per_tenth (register at byte address 0, reset 853, 16 bits
// used). Throughput is one request per clock unless rsp_ready stalls. A
// request passes through five register stages: sine table read,
// four 16x17 multipliers, rim sums,
// rounding and saturation, then four 9x17 rate multipliers. The sine table
// has SINE_ROM_DEPTH+1 entries with two read ports; only sin and cos of the
// base phase are looked up, since the wheels sit a quarter turn apart. Every
// stage holds when the next one is full, so rsp_ready may stall at any time.
module omni_chassis_wheel_speed_solver_core
   import ocws_pkg::*;
#(
   parameter int SINE_ROM_DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [VEL_W-1:0]        req_vel_x,
   input  logic [VEL_W-1:0]        req_vel_y,
   input  logic [VEL_W-1:0]        req_vel_turn,
   input  logic [VEL_W-1:0]        req_heading,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [WHEEL_RATE_W-1:0] rsp_wheel0_rate,
   output logic [WHEEL_RATE_W-1:0] rsp_wheel1_rate,
   output logic [WHEEL_RATE_W-1:0] rsp_wheel2_rate,
   output logic [WHEEL_RATE_W-1:0] rsp_wheel3_rate,
   output logic                    rsp_clipped,
   // register port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam int IDX_W = $clog2(SINE_ROM_DEPTH + 1);
   localparam int JPROD_W = 14 + IDX_W;
   localparam logic [JPROD_W-1:0] DEPTH_MUL = JPROD_W'(SINE_ROM_DEPTH);
   localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(SINE_ROM_DEPTH);

   // ------------------------------------------------------------------
   // register file
   // ------------------------------------------------------------------
   logic [RATE_W-1:0] rate_ff;
   logic [RATE_W-1:0] rate_in;
   logic              csr_write;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // rate update on a write to its address
   always_comb begin
      rate_in = rate_ff;
      if (csr_write && csr_paddr[2] == CSR_IDX_RATE) begin
         rate_in = csr_pwdata[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_RATE) begin
         csr_prdata = {{(CSR_DATA_W-RATE_W){1'b0}}, rate_ff};
      end
   end

   // ------------------------------------------------------------------
   // stall chain
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = ~v5_ff | rsp_ready;
   assign rdy4 = ~v4_ff | rdy5;
   assign rdy3 = ~v3_ff | rdy4;
   assign rdy2 = ~v2_ff | rdy3;
   assign rdy1 = ~v1_ff | rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: phase, table index, table read
   // ------------------------------------------------------------------
   logic [15:0]        base_phase;
   logic [1:0]         quad;
   logic [JPROD_W-1:0] jprod;
   logic [IDX_W-1:0]   j_idx;
   logic [IDX_W-1:0]   idx_a;
   logic [IDX_W-1:0]   idx_b;
   logic [SINE_W-1:0]  rom_a;
   logic [SINE_W-1:0]  rom_b;

   assign base_phase = PHASE_OFFSET - req_heading;
   assign quad = base_phase[15:14];
   assign jprod = {{IDX_W{1'b0}}, base_phase[13:0]} * DEPTH_MUL;
   assign j_idx = jprod[14 +: IDX_W];

   // sin(base) and sin(base + quarter turn) come from mirrored entries
   always_comb begin
      if (quad[0]) begin
         idx_a = DEPTH_IDX - j_idx;
         idx_b = j_idx;
      end else begin
         idx_a = j_idx;
         idx_b = DEPTH_IDX - j_idx;
      end
   end

   ocws_sine_rom #(
      .SINE_ROM_DEPTH (SINE_ROM_DEPTH),
      .IDX_W          (IDX_W)
   ) u_sine_rom (
      .clock  (clock),
      .rd_en  (rdy1),
      .addr_a (idx_a),
      .addr_b (idx_b),
      .data_a (rom_a),
      .data_b (rom_b)
   );

   vel_type s1_vx_ff, s1_vy_ff, s1_vw_ff;
   logic    s1_neg_a_ff, s1_neg_b_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_vx_ff <= req_vel_x;
         s1_vy_ff <= req_vel_y;
         s1_vw_ff <= req_vel_turn;
         s1_neg_a_ff <= quad[1];
         s1_neg_b_ff <= quad[1] ^ quad[0];
      end
   end

   // ------------------------------------------------------------------
   // stage 2: signed sine and cosine, four products
   // ------------------------------------------------------------------
   logic signed [TRIG_W-1:0] trig_a;
   logic signed [TRIG_W-1:0] trig_b;
   prod_type s2_xa_ff, s2_xb_ff, s2_ya_ff, s2_yb_ff;
   vel_type  s2_vw_ff;

   assign trig_a = s1_neg_a_ff ? -$signed({1'b0, rom_a}) : $signed({1'b0, rom_a});
   assign trig_b = s1_neg_b_ff ? -$signed({1'b0, rom_b}) : $signed({1'b0, rom_b});

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_xa_ff <= s1_vx_ff * trig_a;
         s2_xb_ff <= s1_vx_ff * trig_b;
         s2_ya_ff <= s1_vy_ff * trig_a;
         s2_yb_ff <= s1_vy_ff * trig_b;
         s2_vw_ff <= s1_vw_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: rim speed per wheel in Q27
   // ------------------------------------------------------------------
   rim_type xa, xb, ya, yb, turn;
   rim_type rim_in [WHEEL_COUNT];
   rim_type rim_ff [WHEEL_COUNT];

   assign xa = RIM_W'(s2_xa_ff);
   assign xb = RIM_W'(s2_xb_ff);
   assign ya = RIM_W'(s2_ya_ff);
   assign yb = RIM_W'(s2_yb_ff);
   assign turn = {{(RIM_W-VEL_W-15){s2_vw_ff[VEL_W-1]}}, s2_vw_ff, 15'b0};

   // wheel i uses sin(base + i quarters) and cos = sin(base + (i+1) quarters)
   always_comb begin
      rim_in[0] = xb + ya - turn;
      rim_in[1] = yb - xa - turn;
      rim_in[2] = -xb - ya - turn;
      rim_in[3] = xa - yb - turn;
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         rim_ff <= rim_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: round half away from zero to tenths, saturate
   // ------------------------------------------------------------------
   tenths_type   tenths_in [WHEEL_COUNT];
   tenths_type   tenths_ff [WHEEL_COUNT];
   logic [WHEEL_COUNT-1:0] sat_in;
   logic         clip_ff;

   always_comb begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         logic [RIM_W-1:0] neg_rim;
         logic [36:0]      mag;
         logic [36:0]      scaled;
         logic [9:0]       t_raw;
         logic [9:0]       t_sat;
         neg_rim = -rim_ff[i];
         mag = rim_ff[i][RIM_W-1] ? {4'b0, neg_rim[RIM_W-2:0]}
                                  : {4'b0, rim_ff[i][RIM_W-2:0]};
         scaled = (mag << 3) + (mag << 1) + ROUND_HALF;
         t_raw = scaled[36:27];
         sat_in[i] = (t_raw > TENTHS_LIMIT);
         t_sat = sat_in[i] ? TENTHS_LIMIT : t_raw;
         tenths_in[i] = rim_ff[i][RIM_W-1] ? -$signed(t_sat[TENTHS_W-1:0])
                                          : $signed(t_sat[TENTHS_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         tenths_ff <= tenths_in;
         clip_ff <= |sat_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: scale by rate per tenth, output register
   // ------------------------------------------------------------------
   wheel_rate_type wheel_rate_ff [WHEEL_COUNT];
   logic           out_clip_ff;
   logic signed [RATE_W:0] rate_s;

   assign rate_s = $signed({1'b0, rate_ff});

   always_ff @(posedge clock) begin
      if (rdy5) begin
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            wheel_rate_ff[i] <= WHEEL_RATE_W'(tenths_ff[i] * rate_s);
         end
         out_clip_ff <= clip_ff;
      end
   end

   assign rsp_valid = v5_ff;
   assign rsp_wheel0_rate = wheel_rate_ff[0];
   assign rsp_wheel1_rate = wheel_rate_ff[1];
   assign rsp_wheel2_rate = wheel_rate_ff[2];
   assign rsp_wheel3_rate = wheel_rate_ff[3];
   assign rsp_clipped = out_clip_ff;

endmodule

// File: rtl/ocws_port_checker.sv
`include "assert_macros.svh"

module ocws_port_checker
   import ocws_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [WHEEL_RATE_W-1:0] rsp_wheel0_rate,
   input logic                    rsp_clipped
);

   localparam logic [2:0] PIPE_DEPTH = 3'd5;

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid & req_ready;
   assign rsp_take = rsp_valid & rsp_ready;

   // requests accepted and not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 3'd1;
      end else if (!req_take && rsp_take) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "response valid after reset")

   `ASSERT_CLK(a_no_orphan_rsp, clock, reset, rsp_valid |-> pending_ff != 3'd0, "response without request")

   `ASSERT_CLK(a_depth_bound, clock, reset, pending_ff <= PIPE_DEPTH, "more requests in flight than stages")

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wheel0_rate) && $stable(rsp_clipped), "stalled response changed")

endmodule

bind omni_chassis_wheel_speed_solver_core ocws_port_checker u_port_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_wheel0_rate (rsp_wheel0_rate),
   .rsp_clipped     (rsp_clipped)
);

// File: tb/sv/omni_chassis_wheel_speed_solver_core_test.sv
`timescale 1ns / 1ps

module omni_chassis_wheel_speed_solver_core_test;
   import ocws_pkg::*;

   // solver shape and arithmetic constants
   localparam int ROM_DEPTH = 256;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam int TAYLOR_STEPS = 12;
   localparam longint unsigned SINE_CAP = 64'd32768;
   localparam logic [15:0] WHEEL0_PHASE = 16'd24576;
   localparam logic [15:0] QUARTER_TURN = 16'd16384;
   localparam longint unsigned ROUND_TERM = 64'd67108864;
   localparam longint unsigned TENTHS_CAP = 64'd200;
   localparam logic [15:0] RATE_AT_RESET = 16'd853;

   // register map
   localparam logic [CSR_ADDR_W-1:0] RATE_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;

   // run shape
   localparam int IDLE_PERCENT = 36;
   localparam int PIPE_SLACK = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RATE_PHASES = 7;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int DIRECTED_ROWS = 18;

   typedef struct packed {
      logic [WHEEL_COUNT-1:0][WHEEL_RATE_W-1:0] rate;
      logic                                     clipped;
   } wheel_set_type;

   typedef struct packed {
      logic [VEL_W-1:0]        vx;
      logic [VEL_W-1:0]        vy;
      logic [VEL_W-1:0]        vw;
      logic [VEL_W-1:0]        hd;
      logic                    fixed_answer;
      logic [WHEEL_RATE_W-1:0] fixed_rate;
   } stim_row_type;

   // directed requests; rows with a fixed answer have vx = vy = 0 so all
   // four wheels see the same rim speed of -vw
   localparam stim_row_type DIRECTED_TABLE [0:DIRECTED_ROWS-1] = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 25'd0},
      '{16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1, 25'd68240},
      '{16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 1'b1, -25'sd68240},
      // just above half a tenth, rounds away from zero
      '{16'h0000, 16'h0000, -16'sd205, 16'h4000, 1'b1, 25'd853},
      // just below half a tenth, rounds to zero
      '{16'h0000, 16'h0000, -16'sd204, 16'h8000, 1'b1, 25'd0},
      '{16'h0000, 16'h0000, 16'sd205, 16'hC000, 1'b1, -25'sd853},
      '{16'h0000, 16'h0000, 16'sd204, 16'h0001, 1'b1, 25'd0},
      // full-scale velocity along the wheel axes and diagonals
      '{16'h7FFF, 16'h0000, 16'h0000, 16'd24576, 1'b0, 25'd0},
      '{16'h8000, 16'h0000, 16'h0000, 16'd24576, 1'b0, 25'd0},
      '{16'h0000, 16'h7FFF, 16'h0000, 16'd8192, 1'b0, 25'd0},
      '{16'h0000, 16'h8000, 16'h0000, 16'd40960, 1'b0, 25'd0},
      // largest rim magnitudes, closest to the clip level
      '{16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 25'd0},
      '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h4000, 1'b0, 25'd0},
      '{16'h8000, 16'h8000, 16'h7FFF, 16'hE000, 1'b0, 25'd0},
      '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 1'b0, 25'd0},
      // alternating bit patterns
      '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 25'd0},
      '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 25'd0},
      '{16'h0001, 16'hFFFF, 16'h0001, 16'd24575, 1'b0, 25'd0}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [VEL_W-1:0]        req_vel_x;
   logic [VEL_W-1:0]        req_vel_y;
   logic [VEL_W-1:0]        req_vel_turn;
   logic [VEL_W-1:0]        req_heading;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [WHEEL_RATE_W-1:0] rsp_wheel0_rate;
   logic [WHEEL_RATE_W-1:0] rsp_wheel1_rate;
   logic [WHEEL_RATE_W-1:0] rsp_wheel2_rate;
   logic [WHEEL_RATE_W-1:0] rsp_wheel3_rate;
   logic                    rsp_clipped;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   longint unsigned sine_q15_table [0:ROM_DEPTH];
   logic [15:0]     rate_now;
   wheel_set_type   pending_setpoints [$];
   wheel_set_type   seen_set;
   wheel_set_type   want_set;
   logic [31:0]     csr_word;
   int              mismatch_count;
   int              quiet_cycles;
   bit              steady;

   omni_chassis_wheel_speed_solver_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_vel_x       (req_vel_x),
      .req_vel_y       (req_vel_y),
      .req_vel_turn    (req_vel_turn),
      .req_heading     (req_heading),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_wheel0_rate (rsp_wheel0_rate),
      .rsp_wheel1_rate (rsp_wheel1_rate),
      .rsp_wheel2_rate (rsp_wheel2_rate),
      .rsp_wheel3_rate (rsp_wheel3_rate),
      .rsp_clipped     (rsp_clipped),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // quarter-wave sine entry from a truncated Taylor series in Q30
   function automatic longint unsigned sine_entry(input int k);
      longint unsigned x, x2, term, e, n;
      longint signed   total;
      x = longint'(k) * QUARTER_TURN_Q30 / ROM_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      total = longint'(x);
      for (n = 1; n <= TAYLOR_STEPS; n++) begin
         term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n[0]) total = total - longint'(term);
         else total = total + longint'(term);
      end
      if (total < 0) total = 0;
      e = ($unsigned(total) + 64'd16384) >> 15;
      return (e > SINE_CAP) ? SINE_CAP : e;
   endfunction

   // signed Q15 sine of a 16 bit turn fraction
   function automatic longint signed table_sine(input logic [15:0] ph);
      int            j, idx;
      longint signed v;
      j = (int'(ph[13:0]) * ROM_DEPTH) >> 14;
      idx = ph[14] ? ROM_DEPTH - j : j;
      v = longint'(sine_q15_table[idx]);
      return ph[15] ? -v : v;
   endfunction

   // four wheel setpoints and the clip flag for one request
   function automatic wheel_set_type solve_wheel_setpoints(input logic signed [15:0] vx,
                                                            input logic signed [15:0] vy,
                                                            input logic signed [15:0] vw,
                                                            input logic [15:0] hd);
      wheel_set_type   res;
      logic [15:0]     ph;
      longint signed   s, c, rim, tenths, product;
      longint unsigned mag, t;
      res = '0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         ph = WHEEL0_PHASE - hd + 16'(QUARTER_TURN * i);
         s = table_sine(ph);
         c = table_sine(ph + QUARTER_TURN);
         rim = longint'(vx) * c + longint'(vy) * s - longint'(vw) * 32768;
         mag = (rim < 0) ? -rim : rim;
         t = (mag * 10 + ROUND_TERM) >> 27;
         if (t > TENTHS_CAP) begin
            t = TENTHS_CAP;
            res.clipped = 1'b1;
         end
         tenths = (rim < 0) ? -longint'(t) : longint'(t);
         product = tenths * longint'(rate_now);
         res.rate[i] = product[WHEEL_RATE_W-1:0];
      end
      return res;
   endfunction

   // velocity biased toward extremes and the rounding region near zero
   function automatic logic [15:0] pick_velocity();
      logic signed [15:0] v;
      v = 16'($urandom_range(600));
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3, 4: return v - 16'sd300;
         default: return 16'($urandom);
      endcase
   endfunction

   // heading biased toward quadrant boundaries
   function automatic logic [15:0] pick_heading();
      logic [15:0] h;
      h = {2'($urandom_range(3)), 14'h0} + 16'($urandom_range(8)) - 16'd4;
      if ($urandom_range(3) == 0) return h;
      return 16'($urandom);
   endfunction

   // one request, held until accepted
   task automatic send_request(input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] vw, input logic [15:0] hd,
                               input logic fixed_answer,
                               input logic [WHEEL_RATE_W-1:0] fixed_rate);
      wheel_set_type expected;
      if (fixed_answer) begin
         expected.rate = {WHEEL_COUNT{fixed_rate}};
         expected.clipped = 1'b0;
      end else begin
         expected = solve_wheel_setpoints(vx, vy, vw, hd);
      end
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_vel_turn <= vw;
      req_heading <= hd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_setpoints.push_back(expected);
   endtask

   // stop sending and wait for every expected response plus pipeline slack
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   // one register access: setup then access phase
   task automatic csr_cycle(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_rate_readback();
      csr_cycle(1'b0, RATE_ADDR, '0, csr_word);
      if (csr_word[15:0] !== rate_now) begin
         $error("rate_per_tenth: expected %0d, actual %0d", rate_now, csr_word[15:0]);
         mismatch_count++;
      end
   endtask

   // write a register; only the rate address is decoded, 16 bits kept
   task automatic program_rate(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] data);
      csr_cycle(1'b1, addr, data, csr_word);
      if (addr == RATE_ADDR) rate_now = data[15:0];
      check_rate_readback();
   endtask

   // result sink with random stalls
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_setpoints.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want_set = pending_setpoints.pop_front();
            seen_set.rate[0] = rsp_wheel0_rate;
            seen_set.rate[1] = rsp_wheel1_rate;
            seen_set.rate[2] = rsp_wheel2_rate;
            seen_set.rate[3] = rsp_wheel3_rate;
            seen_set.clipped = rsp_clipped;
            for (int i = 0; i < WHEEL_COUNT; i++) begin
               if (seen_set.rate[i] !== want_set.rate[i]) begin
                  $error("wheel%0d_rate: expected %0d, actual %0d", i,
                         $signed(want_set.rate[i]), $signed(seen_set.rate[i]));
                  mismatch_count++;
               end
            end
            if (seen_set.clipped !== want_set.clipped) begin
               $error("clipped: expected %0d, actual %0d", want_set.clipped,
                      seen_set.clipped);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // main sequence
   initial begin
      int phase, n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_vel_turn = '0;
      req_heading = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatch_count = 0;
      quiet_cycles = 0;
      steady = 1'b0;
      rate_now = RATE_AT_RESET;
      for (int k = 0; k <= ROM_DEPTH; k++) sine_q15_table[k] = sine_entry(k);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_rate_readback();

      // directed table at the reset rate
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_request(DIRECTED_TABLE[r].vx, DIRECTED_TABLE[r].vy, DIRECTED_TABLE[r].vw,
                      DIRECTED_TABLE[r].hd, DIRECTED_TABLE[r].fixed_answer,
                      DIRECTED_TABLE[r].fixed_rate);
      end

      // random requests, one rate setting per phase
      for (phase = 0; phase < RATE_PHASES; phase++) begin
         drain_pipeline();
         case (phase)
            0: program_rate(RATE_ADDR, 32'hFFFF_FFFF);
            1: program_rate(RATE_ADDR, 32'h5A5A_0001);
            2: program_rate(RATE_ADDR, 32'h0000_0000);
            3: program_rate(RATE_ADDR, {16'($urandom), 16'($urandom_range(1, 65535))});
            4: begin
               program_rate(RATE_ADDR, 32'(RATE_AT_RESET));
               // unmapped register, must leave the rate alone
               program_rate(SPARE_ADDR, 32'h0000_1234);
            end
            default: program_rate(RATE_ADDR, $urandom);
         endcase
         steady = (phase == 3);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 5 && n == ITEMS_PER_PHASE / 2) drain_pipeline();
            send_request(pick_velocity(), pick_velocity(), pick_velocity(), pick_heading(),
                         1'b0, '0);
         end
      end
      steady = 1'b0;
      drain_pipeline();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ocws_pkg.sv
rtl/ocws_sine_rom.sv
rtl/omni_chassis_wheel_speed_solver_core.sv
rtl/ocws_port_checker.sv
tb/sv/omni_chassis_wheel_speed_solver_core_test.sv
